/* src/adcld_pkg.sv */
// shared types, constants and register map of the adc channel lowpass decimator
package adcld_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    // configuration port geometry
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;

    // register indexes (byte address is 8 * index)
    localparam logic [1:0] REG_SAMPLE_RATE  = 2'd0;
    localparam logic [1:0] REG_CHANNEL_MASK = 2'd1;
    localparam logic [1:0] REG_RATIOS_LOW   = 2'd2;
    localparam logic [1:0] REG_RATIOS_HIGH  = 2'd3;

    // register reset values
    localparam logic [15:0] SAMPLE_RATE_RESET = 16'd51200;
    localparam logic [7:0]  CHANNEL_MASK_RESET = 8'd0;
    localparam logic [63:0] RATIOS_RESET = 64'h0001_0001_0001_0001;

    // sample rates that select a coefficient set
    localparam logic [15:0] RATE_HIGH  = 16'd25600;
    localparam logic [15:0] RATE_MID_A = 16'd12800;
    localparam logic [15:0] RATE_MID_B = 16'd6400;
    localparam logic [15:0] RATE_MID_C = 16'd3200;

    // lowpass coefficients, q16
    localparam logic signed [16:0] B_HIGH = 17'sd22451;
    localparam logic signed [16:0] A_HIGH = 17'sd20706;
    localparam logic signed [16:0] B_MID  = 17'sd12870;
    localparam logic signed [16:0] A_MID  = 17'sd39795;

    typedef logic signed [15:0] raw_t;
    typedef logic signed [16:0] filt_t;

    // per channel state word held in the state ram
    typedef struct packed {
        logic signed [31:0] acc;
        logic signed [15:0] prev;
        logic [15:0]        dec_count;
        logic [15:0]        store_idx;
    } chan_state_t;

endpackage

/* src/adcld_ram.sv */
// generic single write port ram with one registered read port
module adcld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/adc_channel_lowpass_decimator_core.sv */
// top level of the multichannel first order lowpass decimator
//
// raw_valid/raw_stall carries one converter sample (raw_sample, channel) per beat;
// result_valid/result_stall carries one result beat. a beat moves at a rising
// edge where valid is high and stall is low. the user must write configuration
// over the apb port only while no sample is in flight; the block does not enforce it.
// channels at or above NUM_CHANNELS are taken and dropped without effect.
// a taken sample waits in the compute stage until the output register is free,
// then its result (if any) is loaded there; one sample is taken every cycle
// while the result side keeps up.
// the rate is set by the single read-modify-write stage on the per channel
// state ram: read at the input beat, compute and write back as the stage fires,
// with the last written entry forwarded when the next sample hits the same
// channel.
// reset loads the register defaults and clears the scan count, bank and the per
// channel live bits; a channel whose live bit is clear reads as zero state, so
// there is no clearing pass. a block end clears the counter live bits the same way.
// when result_stall holds a waiting result, the compute stage and then the
// input stall; nothing is dropped.
module adc_channel_lowpass_decimator_core #(
    parameter int NUM_CHANNELS = adcld_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // apb configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [adcld_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [adcld_pkg::APB_DATA_W-1:0] pwdata,
    output logic [adcld_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // sample channel
    input  logic                           raw_valid,
    output logic                           raw_stall,
    input  adcld_pkg::raw_t                raw_sample,
    input  logic [2:0]                     channel,
    // result channel
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           sample_valid,
    output adcld_pkg::filt_t               filtered_sample,
    output logic [2:0]                     out_channel,
    output logic [15:0]                    store_index,
    output logic                           bank,
    output logic                           block_done
);

    import adcld_pkg::*;

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [2:0] LAST_CH = 3'(NUM_CHANNELS - 1);
    localparam int ENTRY_W = $bits(chan_state_t);

    // configuration registers
    logic [15:0] sample_rate_reg;
    logic [7:0]  channel_mask_reg;
    logic [63:0] ratios_low_reg;
    logic [63:0] ratios_high_reg;
    logic        cfg_wr;

    // input and compute stage
    logic              accept;
    logic              chan_ok;
    logic              rd_en;
    logic              s1_vld_reg;
    logic [2:0]        s1_chan_reg;
    raw_t              s1_x_reg;
    logic              s1_ready;
    logic              s1_fire;
    logic              out_free;
    logic [ADDR_W-1:0] s1_addr;

    // state ram and forwarding
    logic [ENTRY_W-1:0] ram_rd_data;
    chan_state_t        ram_q;
    chan_state_t        fwd_data_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic               fwd_vld_reg;
    chan_state_t        ent_raw;
    chan_state_t        wr_entry;
    logic               wr_en;
    logic [NUM_CHANNELS-1:0] filt_live_reg;
    logic [NUM_CHANNELS-1:0] cnt_live_reg;

    // scan tracking
    logic [15:0] scan_reg;
    logic        bank_reg;

    // compute signals
    logic signed [31:0] acc_cur;
    logic signed [15:0] prev_cur;
    logic [15:0]        dec_cur;
    logic [15:0]        idx_cur;
    logic               mask_on;
    logic               do_filt;
    logic signed [16:0] coef_b;
    logic signed [16:0] coef_a;
    logic signed [16:0] sum_x;
    logic signed [33:0] prod_b;
    logic signed [48:0] prod_a;
    logic signed [49:0] sum_total;
    logic signed [31:0] acc_new;
    filt_t              y_val;
    logic [63:0]        ratio_word;
    logic [15:0]        ratio;
    logic [15:0]        dec_inc;
    logic               emit;
    logic               is_last;
    logic [15:0]        scan_inc;
    logic               done;
    logic               has_res;

    // output register
    logic        result_valid_reg;
    logic        sample_valid_reg;
    filt_t       filtered_sample_reg;
    logic [2:0]  out_channel_reg;
    logic [15:0] store_index_reg;
    logic        bank_out_reg;
    logic        block_done_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg  <= SAMPLE_RATE_RESET;
            channel_mask_reg <= CHANNEL_MASK_RESET;
            ratios_low_reg   <= RATIOS_RESET;
            ratios_high_reg  <= RATIOS_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                REG_SAMPLE_RATE:  sample_rate_reg  <= pwdata[15:0];
                REG_CHANNEL_MASK: channel_mask_reg <= pwdata[7:0];
                REG_RATIOS_LOW:   ratios_low_reg   <= pwdata;
                REG_RATIOS_HIGH:  ratios_high_reg  <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_SAMPLE_RATE:  prdata = {48'd0, sample_rate_reg};
            REG_CHANNEL_MASK: prdata = {56'd0, channel_mask_reg};
            REG_RATIOS_LOW:   prdata = ratios_low_reg;
            REG_RATIOS_HIGH:  prdata = ratios_high_reg;
            default:          prdata = '0;
        endcase
    end

    // input handshake
    assign out_free  = !result_valid_reg || !result_stall;
    assign s1_ready  = !s1_vld_reg || out_free;
    assign s1_fire   = s1_vld_reg && out_free;
    assign raw_stall = !s1_ready;
    assign accept    = raw_valid && s1_ready;
    assign chan_ok   = int'(channel) < NUM_CHANNELS;
    assign rd_en     = accept && chan_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_chan_reg <= channel;
            s1_x_reg    <= raw_sample;
        end
    end

    adcld_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (NUM_CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (channel[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign ram_q   = ram_rd_data;
    assign s1_addr = s1_chan_reg[ADDR_W-1:0];

    // the ram read races the previous write to the same entry
    assign ent_raw = (fwd_vld_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : ram_q;

    always_comb
    begin
        acc_cur  = filt_live_reg[s1_addr] ? ent_raw.acc  : '0;
        prev_cur = filt_live_reg[s1_addr] ? ent_raw.prev : '0;
        dec_cur  = cnt_live_reg[s1_addr]  ? ent_raw.dec_count : '0;
        idx_cur  = cnt_live_reg[s1_addr]  ? ent_raw.store_idx : '0;
    end

    // coefficient set from the sample rate; any other rate selects pass-through
    always_comb
    begin
        do_filt = 1'b1;
        coef_b  = B_HIGH;
        coef_a  = A_HIGH;
        if (sample_rate_reg == RATE_HIGH)
        begin
            coef_b = B_HIGH;
            coef_a = A_HIGH;
        end
        else if (sample_rate_reg == RATE_MID_A || sample_rate_reg == RATE_MID_B ||
                 sample_rate_reg == RATE_MID_C)
        begin
            coef_b = B_MID;
            coef_a = A_MID;
        end
        else
        begin
            do_filt = 1'b0;
        end
    end

    // first order lowpass, full width sum then floor shift by 16
    assign sum_x     = {s1_x_reg[15], s1_x_reg} + {prev_cur[15], prev_cur};
    assign prod_b    = sum_x * coef_b;
    assign prod_a    = acc_cur * coef_a;
    assign sum_total = {{16{prod_b[33]}}, prod_b} + {prod_a[48], prod_a};
    assign acc_new   = sum_total[47:16];
    assign y_val     = do_filt ? acc_new[16:0] : {s1_x_reg[15], s1_x_reg};

    // decimation
    assign mask_on    = channel_mask_reg[s1_chan_reg];
    assign ratio_word = s1_chan_reg[2] ? ratios_high_reg : ratios_low_reg;
    assign ratio      = ratio_word[{s1_chan_reg[1:0], 4'b0000} +: 16];
    assign dec_inc    = dec_cur + 16'd1;
    assign emit       = dec_inc >= ratio;

    // scan end and block end
    assign is_last  = s1_chan_reg == LAST_CH;
    assign scan_inc = scan_reg + 16'd1;
    assign done     = is_last && (scan_inc >= sample_rate_reg);
    assign has_res  = (mask_on && emit) || done;

    assign wr_en = s1_fire && mask_on;

    always_comb
    begin
        wr_entry.acc       = do_filt ? acc_new : acc_cur;
        wr_entry.prev      = do_filt ? s1_x_reg : prev_cur;
        wr_entry.dec_count = emit ? 16'd0 : dec_inc;
        wr_entry.store_idx = emit ? idx_cur + 16'd1 : idx_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg   <= 1'b0;
            filt_live_reg <= '0;
            cnt_live_reg  <= '0;
            scan_reg      <= '0;
            bank_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                fwd_vld_reg            <= 1'b1;
                filt_live_reg[s1_addr] <= 1'b1;
            end
            if (s1_fire && done)
            begin
                cnt_live_reg <= '0;
            end
            else if (wr_en)
            begin
                cnt_live_reg[s1_addr] <= 1'b1;
            end
            if (s1_fire && is_last)
            begin
                scan_reg <= done ? 16'd0 : scan_inc;
                if (done)
                begin
                    bank_reg <= !bank_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= wr_entry;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= s1_fire && has_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_res)
        begin
            sample_valid_reg    <= mask_on && emit;
            filtered_sample_reg <= (mask_on && emit) ? y_val : '0;
            out_channel_reg     <= (mask_on && emit) ? s1_chan_reg : 3'd0;
            store_index_reg     <= (mask_on && emit) ? idx_cur : 16'd0;
            bank_out_reg        <= bank_reg;
            block_done_reg      <= done;
        end
    end

    assign result_valid    = result_valid_reg;
    assign sample_valid    = sample_valid_reg;
    assign filtered_sample = filtered_sample_reg;
    assign out_channel     = out_channel_reg;
    assign store_index     = store_index_reg;
    assign bank            = bank_out_reg;
    assign block_done      = block_done_reg;

    // a result without a sample only comes from a block end
    a_empty_result_is_block_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !sample_valid |-> block_done && store_index == 16'd0
    ) else $error("result without sample that is not a block end");

    // a block end leaves every counter entry reading as zero
    a_block_end_clears_counters: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_fire && done |=> cnt_live_reg == '0
    ) else $error("counter live bits not cleared at block end");

    // an empty compute stage never stalls the input
    a_no_stall_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s1_vld_reg |-> !raw_stall
    ) else $error("input stalled with empty compute stage");

endmodule

/* bench/tb_top.sv */
// self-checking bench for the multichannel lowpass decimator core
`timescale 1ns / 1ps

module tb_top;
    import adcld_pkg::*;

    localparam int NUM_CH = NUM_CHANNELS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        sv;
        filt_t       fs;
        logic [2:0]  ch;
        logic [15:0] idx;
        logic        bk;
        logic        bd;
    } out_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  raw_valid = 1'b0;
    logic                  raw_stall;
    raw_t                  raw_sample = '0;
    logic [2:0]            channel = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  sample_valid;
    filt_t                 filtered_sample;
    logic [2:0]            out_channel;
    logic [15:0]           store_index;
    logic                  bank;
    logic                  block_done;

    // mirror of the block's configuration and per channel state
    logic [15:0]        cfg_rate;
    logic [7:0]         cfg_mask;
    logic [63:0]        cfg_ratio_lo;
    logic [63:0]        cfg_ratio_hi;
    logic signed [31:0] lp_acc [NUM_CH];
    raw_t               prev_in [NUM_CH];
    logic [15:0]        dec_count [NUM_CH];
    logic [15:0]        next_idx [NUM_CH];
    logic [15:0]        scan_count;
    logic               cur_bank;

    out_beat_t decimated_q[$];
    out_beat_t got_beat;
    out_beat_t want_beat;

    int  mismatch_count = 0;
    int  samples_sent = 0;
    int  beats_checked = 0;
    int  blocks_ended = 0;
    int  reg_writes = 0;
    int  idle_cycles = 0;

    bit  stall_mode = 1'b0;
    bit  gaps_on = 1'b0;
    int  hold_request = 0;
    int  hold_left = 0;
    int  stall_run = 0;

    adc_channel_lowpass_decimator_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .raw_valid       (raw_valid),
        .raw_stall       (raw_stall),
        .raw_sample      (raw_sample),
        .channel         (channel),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .sample_valid    (sample_valid),
        .filtered_sample (filtered_sample),
        .out_channel     (out_channel),
        .store_index     (store_index),
        .bank            (bank),
        .block_done      (block_done)
    );

    always #6 clk = ~clk;

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic raw_t pick_raw();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return raw_t'($urandom_range(0, 15)) - 16'sd8;
            default: return raw_t'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_ratio_word();
        logic [63:0] w;
        int k;
        for (k = 0; k < 4; k++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: w[16*k +: 16] = 16'd0;
                4, 5, 6, 7, 8, 9: w[16*k +: 16] = 16'd1;
                10, 11, 12, 13, 14, 15: w[16*k +: 16] = 16'($urandom_range(2, 4));
                16: w[16*k +: 16] = 16'hFFFF;
                default: w[16*k +: 16] = 16'($urandom);
            endcase
        end
        return w;
    endfunction

    task automatic lowpass_state_reset();
        int c;
        cfg_rate = SAMPLE_RATE_RESET;
        cfg_mask = CHANNEL_MASK_RESET;
        cfg_ratio_lo = RATIOS_RESET;
        cfg_ratio_hi = RATIOS_RESET;
        for (c = 0; c < NUM_CH; c++)
        begin
            lp_acc[c] = '0;
            prev_in[c] = '0;
            dec_count[c] = '0;
            next_idx[c] = '0;
        end
        scan_count = '0;
        cur_bank = 1'b0;
    endtask

    // one accepted sample: filter, decimate, scan bookkeeping
    function automatic void filter_and_decimate(input raw_t x, input logic [2:0] ch);
        out_beat_t   beat;
        longint      coef_b;
        longint      coef_a;
        longint      s;
        logic [63:0] word;
        logic [15:0] ratio;
        logic        emit;
        logic        ended;
        logic        filt;
        filt_t       y;
        logic [15:0] idx;
        logic        bank_was;
        int          c;
        emit = 1'b0;
        ended = 1'b0;
        idx = '0;
        bank_was = cur_bank;
        y = {x[15], x};
        coef_b = 0;
        coef_a = 0;
        if (ch >= NUM_CH)
            return;
        if (cfg_mask[ch])
        begin
            filt = 1'b1;
            if (cfg_rate == RATE_HIGH)
            begin
                coef_b = B_HIGH;
                coef_a = A_HIGH;
            end
            else if (cfg_rate == RATE_MID_A || cfg_rate == RATE_MID_B ||
                     cfg_rate == RATE_MID_C)
            begin
                coef_b = B_MID;
                coef_a = A_MID;
            end
            else
            begin
                filt = 1'b0;
            end
            if (filt)
            begin
                s = (longint'(x) + longint'(prev_in[ch])) * coef_b +
                    longint'(lp_acc[ch]) * coef_a;
                lp_acc[ch] = 32'(s >>> 16);
                prev_in[ch] = x;
                y = lp_acc[ch][16:0];
            end
            word = (ch < 4) ? cfg_ratio_lo : cfg_ratio_hi;
            ratio = word[16*ch[1:0] +: 16];
            dec_count[ch] = dec_count[ch] + 16'd1;
            if (dec_count[ch] >= ratio)
            begin
                dec_count[ch] = '0;
                emit = 1'b1;
                idx = next_idx[ch];
                next_idx[ch] = next_idx[ch] + 16'd1;
            end
        end
        if (ch == NUM_CH - 1)
        begin
            scan_count = scan_count + 16'd1;
            if (scan_count >= cfg_rate)
            begin
                for (c = 0; c < NUM_CH; c++)
                begin
                    dec_count[c] = '0;
                    next_idx[c] = '0;
                end
                scan_count = '0;
                cur_bank = ~cur_bank;
                ended = 1'b1;
            end
        end
        if (!emit && !ended)
            return;
        beat.sv = emit;
        beat.fs = emit ? y : '0;
        beat.ch = emit ? ch : '0;
        beat.idx = emit ? idx : '0;
        beat.bk = bank_was;
        beat.bd = ended;
        decimated_q.push_back(beat);
        if (ended)
            blocks_ended++;
    endfunction

    // apb write: setup, access, then idle
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_SAMPLE_RATE:  cfg_rate = value[15:0];
            REG_CHANNEL_MASK: cfg_mask = value[7:0];
            REG_RATIOS_LOW:   cfg_ratio_lo = value;
            REG_RATIOS_HIGH:  cfg_ratio_hi = value;
            default: ;
        endcase
        reg_writes++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] rate, input logic [7:0] mask,
                             input logic [63:0] lo, input logic [63:0] hi);
        write_reg(REG_SAMPLE_RATE, 64'(rate));
        write_reg(REG_CHANNEL_MASK, 64'(mask));
        write_reg(REG_RATIOS_LOW, lo);
        write_reg(REG_RATIOS_HIGH, hi);
    endtask

    task automatic send_sample(input raw_t x, input logic [2:0] ch);
        int gap;
        raw_valid <= 1'b1;
        raw_sample <= x;
        channel <= ch;
        do @(posedge clk); while (raw_stall !== 1'b0);
        filter_and_decimate(x, ch);
        samples_sent++;
        gap = 0;
        if (gaps_on && $urandom_range(0, 1) == 1)
            gap = pick_idle_len();
        if (gap > 0)
        begin
            raw_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_scan(input int first, input int last);
        int c;
        for (c = first; c <= last; c++)
            send_sample(pick_raw(), 3'(c));
    endtask

    // sender idles until every predicted beat is out and the pipe is empty
    task automatic wait_results_drained();
        raw_valid <= 1'b0;
        while (decimated_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        stall_mode = 1'b0;
        gaps_on = 1'b0;
        // high rate coefficients, every channel, ratio one
        configure(RATE_HIGH, 8'hFF, RATIOS_RESET, RATIOS_RESET);
        send_sample(16'sh7FFF, 3'd0);
        send_sample(16'sh7FFF, 3'd0);
        send_sample(16'sh8000, 3'd1);
        send_sample(16'sh8000, 3'd1);
        send_sample(16'sd0, 3'd2);
        send_sample(-16'sd1, 3'd3);
        send_sample(16'sd1, 3'd7);
        wait_results_drained();
        // mid coefficients, highest channel masked off
        configure(RATE_MID_B, 8'h7F, RATIOS_RESET, RATIOS_RESET);
        send_sample(16'sh7FFF, 3'd4);
        send_sample(16'sh8000, 3'd4);
        send_sample(16'sd12345, 3'd5);
        send_sample(-16'sd7, 3'd7);
        wait_results_drained();
        // rate zero: each scan ends a block, here without a sample; zero ratio
        configure(16'd0, 8'h01, 64'h0, RATIOS_RESET);
        send_sample(16'sh7FFF, 3'd0);
        send_sample(16'sh8000, 3'd0);
        send_sample(16'sd5, 3'd7);
        send_sample(16'sd7, 3'd0);
        wait_results_drained();
        // sample and block end in the same beat
        configure(16'd1, 8'h80, RATIOS_RESET, 64'h0);
        send_sample(16'sh7FFF, 3'd7);
        send_sample(16'sh8000, 3'd7);
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        configure(RATE_HIGH, 8'hFF, RATIOS_RESET, RATIOS_RESET);
        stall_mode = 1'b0;
        gaps_on = 1'b0;
        hold_request = 300;
        repeat (5) send_scan(0, 7);
        wait_results_drained();
        stall_mode = 1'b1;
        repeat (3) send_scan(0, 7);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int          p;
        int          sent;
        int          first;
        int          last;
        logic [15:0] rate;
        logic [7:0]  mask;
        for (p = 0; p < 9; p++)
        begin
            case ($urandom_range(0, 9))
                0: rate = RATE_HIGH;
                1: rate = RATE_MID_A;
                2: rate = RATE_MID_B;
                3: rate = RATE_MID_C;
                4: rate = 16'd0;
                5: rate = 16'd1;
                6: rate = 16'hFFFF;
                7: rate = 16'($urandom);
                default: rate = 16'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 5))
                0, 1, 2: mask = 8'hFF;
                3: mask = 8'h00;
                default: mask = 8'($urandom);
            endcase
            configure(rate, mask, pick_ratio_word(), pick_ratio_word());
            case (p % 4)
                0:
                begin
                    stall_mode = 1'b1;
                    gaps_on = 1'b1;
                end
                1:
                begin
                    stall_mode = 1'b1;
                    gaps_on = 1'b0;
                end
                2:
                begin
                    stall_mode = 1'b0;
                    gaps_on = 1'b1;
                end
                default:
                begin
                    stall_mode = 1'b0;
                    gaps_on = 1'b0;
                end
            endcase
            sent = 0;
            while (sent < 150)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    send_scan(0, NUM_CH - 1);
                    sent += NUM_CH;
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    // broken scan
                    first = $urandom_range(0, NUM_CH - 1);
                    last = $urandom_range(first, NUM_CH - 1);
                    send_scan(first, last);
                    sent += last - first + 1;
                end
                else
                begin
                    send_sample(pick_raw(), 3'($urandom_range(0, 7)));
                    sent++;
                end
            end
            wait_results_drained();
        end
    endtask

    // filter state carries over block ends taken while pass-through is selected
    task automatic test_filtered_block_end();
        configure(RATE_MID_C, 8'hFF, 64'h0003_0002_0001_0000, 64'h0000_0005_0001_0004);
        stall_mode = 1'b1;
        gaps_on = 1'b0;
        repeat (6) send_scan(0, NUM_CH - 1);
        wait_results_drained();
        configure(16'd2, 8'hFF, RATIOS_RESET, RATIOS_RESET);
        repeat (4) send_scan(0, NUM_CH - 1);
        wait_results_drained();
        configure(RATE_MID_C, 8'hFF, 64'h0003_0002_0001_0000, 64'h0000_0005_0001_0004);
        repeat (6) send_scan(0, NUM_CH - 1);
        wait_results_drained();
    endtask

    // store index climbs through a long block on two channels without a block end
    task automatic test_long_block();
        configure(16'hFFFF, 8'h81, RATIOS_RESET, RATIOS_RESET);
        stall_mode = 1'b0;
        gaps_on = 1'b0;
        repeat (150) send_sample(pick_raw(), 3'd0);
        repeat (100) send_sample(pick_raw(), 3'd7);
        wait_results_drained();
    endtask

    // receiver side: long hold-offs on request, else random stalls in stall mode
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_request > 0)
        begin
            hold_left = hold_request - 1;
            hold_request = 0;
            result_stall <= 1'b1;
        end
        else if (!stall_mode)
        begin
            result_stall <= 1'b0;
        end
        else if (stall_run > 0)
        begin
            stall_run = stall_run - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 2) == 0);
            stall_run = pick_idle_len();
        end
    end

    always @(posedge clk)
    begin
        if (result_valid === 1'b1 && result_stall === 1'b0)
        begin
            got_beat.sv = sample_valid;
            got_beat.fs = filtered_sample;
            got_beat.ch = out_channel;
            got_beat.idx = store_index;
            got_beat.bk = bank;
            got_beat.bd = block_done;
            beats_checked++;
            if (decimated_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected beat: valid=%0d sample=%0d ch=%0d",
                             got_beat.sv, $signed(got_beat.fs), got_beat.ch,
                             " idx=%0d bank=%0d done=%0d",
                             got_beat.idx, got_beat.bk, got_beat.bd);
            end
            else
            begin
                want_beat = decimated_q.pop_front();
                if (got_beat !== want_beat)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: want valid=%0d sample=%0d ch=%0d",
                                 want_beat.sv, $signed(want_beat.fs), want_beat.ch,
                                 " idx=%0d bank=%0d done=%0d",
                                 want_beat.idx, want_beat.bk, want_beat.bd);
                        $display("          got valid=%0d sample=%0d ch=%0d",
                                 got_beat.sv, $signed(got_beat.fs), got_beat.ch,
                                 " idx=%0d bank=%0d done=%0d",
                                 got_beat.idx, got_beat.bk, got_beat.bd);
                    end
                end
            end
        end
    end

    // ends the run when no beat moves for too long
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((raw_valid === 1'b1 && raw_stall === 1'b0) ||
                (result_valid === 1'b1 && result_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles, %0d beats pending",
                 WATCHDOG_LIMIT, decimated_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        lowpass_state_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_backpressure();
        test_random_traffic();
        test_filtered_block_end();
        test_long_block();
        $display("run covered %0d samples, %0d result beats, %0d block ends, %0d register writes",
                 samples_sent, beats_checked, blocks_ended, reg_writes);
        $display("settings spanned both coefficient sets, pass-through, rates 0/1/max and zero ratios");
        if (mismatch_count == 0 && decimated_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
src/adcld_pkg.sv
src/adcld_ram.sv
src/adc_channel_lowpass_decimator_core.sv
bench/tb_top.sv
